// File: hw/rtl/frq_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point requantizer package
// Shared widths, register indexes, configuration bundle and saturation helper.
// ----------------------------------------------------------------------------
package frq_pkg;

    // Accumulator bits that carry information; the rest of acc_value is ignored.
    localparam int ACC_WIDTH  = 32;
    localparam int ACC_PAD    = 32 - ACC_WIDTH;

    // Register stages from the input beat to the output register.
    localparam int NUM_STAGES = 6;

    localparam int MUL_WIDTH  = 31;
    localparam int SHF_WIDTH  = 6;
    localparam int CFG_WIDTH  = MUL_WIDTH;

    localparam logic [MUL_WIDTH-1:0] MUL_RESET = 31'h4000_0000;

    localparam logic signed [63:0] INT32_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] INT32_MIN_W = -64'sd2147483648;

    // Nudges of the rounding doubling high multiply.
    localparam logic signed [63:0] NUDGE_POS = 64'sd1073741824;
    localparam logic signed [63:0] NUDGE_NEG = 64'sd1 - 64'sd1073741824;

    typedef enum logic [1:0] {
        CFG_MULTIPLIER = 2'd0,
        CFG_EXP_SHIFT  = 2'd1,
        CFG_ROUND_MODE = 2'd2
    } cfg_idx_t;

    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    typedef struct packed {
        logic [MUL_WIDTH-1:0] multiplier;
        logic [SHF_WIDTH-1:0] exponent_shift;
        logic                 rounding_mode;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } sat_t;

    // Clamp a wide signed value to int32 and flag the clamp.
    function automatic sat_t sat_int32(input logic signed [63:0] v);
        sat_t r;
        if (v > INT32_MAX_W) begin
            r.val  = 32'sh7FFF_FFFF;
            r.clip = 1'b1;
        end
        else if (v < INT32_MIN_W) begin
            r.val  = 32'sh8000_0000;
            r.clip = 1'b1;
        end
        else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/frq_cfg_regs.sv
// ----------------------------------------------------------------------------
// Requantizer configuration registers
// Write-only register file for multiplier, exponent shift and rounding mode.
// ----------------------------------------------------------------------------
module frq_cfg_regs
    import frq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    logic [MUL_WIDTH-1:0] multiplier_reg;
    logic [SHF_WIDTH-1:0] shift_reg;
    logic                 mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= MUL_RESET;
            shift_reg      <= '0;
            mode_reg       <= MODE_DOUBLE;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MULTIPLIER: multiplier_reg <= cfg_wdata[MUL_WIDTH-1:0];
                CFG_EXP_SHIFT:  shift_reg      <= cfg_wdata[SHF_WIDTH-1:0];
                CFG_ROUND_MODE: mode_reg       <= cfg_wdata[0];
                default:        ; // drop writes to unmapped indexes
            endcase
        end
    end

    assign cfg.multiplier     = multiplier_reg;
    assign cfg.exponent_shift = shift_reg;
    assign cfg.rounding_mode  = mode_reg;

endmodule

// File: hw/rtl/fixed_point_requantizer_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point requantizer
// Scales signed accumulators by a Q31 multiplier and power-of-two exponent.
// ----------------------------------------------------------------------------
// Takes one accumulator beat per cycle while acc_ready is high and returns one
// result beat per input, in order. A result is presented from the output register
// once its beat has passed through every stage, and is held while res_ready is low.
// The datapath is a six-stage pipeline: pre-shift and clamp, 32x32 multiply,
// rounding add, coarse shift, rounding divide by a power of two, and final
// int32 saturation in the output register. Each stage keeps its own valid
// bit and holds only while it is full and the stage after it is stalled, so
// bubbles collapse and acc_ready stays high while any stage can still move.
// Rounding mode 0 rounds (x*mul) >> (31-exp) half toward plus infinity; mode 1
// applies the doubling high multiply with a sign-dependent nudge, then a
// divide by 2^-exp that rounds half away from zero, with a positive exponent
// pre-shifting the input. clipped flags any clamp to the int32 range, and
// last_in travels with its beat to last_out. Write configuration only while
// the pipeline is empty; the registers feed all stages but the last directly.
// ----------------------------------------------------------------------------
module fixed_point_requantizer_unit
    import frq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // accumulator channel
    input  logic                 acc_valid,
    output logic                 acc_ready,
    input  logic signed [31:0]   acc_value,
    input  logic                 last_in,
    // result channel
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic signed [31:0]   scaled_value,
    output logic                 clipped,
    output logic                 last_out,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata
);

    cfg_t cfg;

    frq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Pipeline control: per-stage valid with a ready chain from the back.
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   vld_next;
    logic [NUM_STAGES+1:1] adv;

    always_comb
    begin
        adv[NUM_STAGES+1] = res_ready;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[1] = acc_valid;
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign acc_ready = adv[1];

    // ------------------------------------------------------------------
    // Shift amounts derived from the exponent register.
    // ------------------------------------------------------------------
    logic signed [SHF_WIDTH-1:0] shf;
    logic                        shf_pos;
    logic [6:0]                  s_wide;
    logic [5:0]                  s_amt;   // single rounding right shift, 0..63
    logic [5:0]                  rs_amt;  // double rounding divide, 0..32

    assign shf     = $signed(cfg.exponent_shift);
    assign shf_pos = !shf[SHF_WIDTH-1] && (shf != '0);
    assign s_wide  = 7'd31 - {shf[SHF_WIDTH-1], shf};
    assign s_amt   = s_wide[5:0];
    assign rs_amt  = shf[SHF_WIDTH-1] ? (6'd0 - cfg.exponent_shift) : 6'd0;

    // ------------------------------------------------------------------
    // Stage 1: sign-extend, pre-shift for double rounding, clamp.
    // ------------------------------------------------------------------
    logic signed [31:0] x_ext;
    logic signed [63:0] pre_w;
    sat_t               pre_sat;
    logic signed [31:0] s1_op_next;
    logic               s1_clip_next;
    logic signed [31:0] s1_op_reg;
    logic               s1_clip_reg;
    logic               s1_last_reg;

    assign x_ext   = $signed(acc_value <<< ACC_PAD) >>> ACC_PAD;
    assign pre_w   = 64'(x_ext) <<< cfg.exponent_shift[4:0];
    assign pre_sat = sat_int32(pre_w);

    always_comb
    begin
        if (cfg.rounding_mode == MODE_DOUBLE && shf_pos)
        begin
            s1_op_next   = pre_sat.val;
            s1_clip_next = pre_sat.clip;
        end
        else
        begin
            s1_op_next   = x_ext;
            s1_clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_op_reg   <= s1_op_next;
            s1_clip_reg <= s1_clip_next;
            s1_last_reg <= last_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signed 32x32 multiply.
    // ------------------------------------------------------------------
    logic signed [31:0] mul_s;
    logic signed [63:0] s2_prod_next;
    logic signed [63:0] s2_prod_reg;
    logic               s2_clip_reg;
    logic               s2_last_reg;

    assign mul_s        = $signed({1'b0, cfg.multiplier});
    assign s2_prod_next = s1_op_reg * mul_s;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_prod_reg <= s2_prod_next;
            s2_clip_reg <= s1_clip_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add the rounding term (half-up bias or sign nudge).
    // ------------------------------------------------------------------
    logic signed [63:0] rnd_term;
    logic signed [63:0] s3_sum_next;
    logic signed [63:0] s3_sum_reg;
    logic               s3_clip_reg;
    logic               s3_last_reg;

    always_comb
    begin
        if (cfg.rounding_mode == MODE_SINGLE)
        begin
            rnd_term = (s_amt != 6'd0) ? (64'sd1 <<< (s_amt - 6'd1)) : 64'sd0;
        end
        else
        begin
            rnd_term = s2_prod_reg[63] ? NUDGE_NEG : NUDGE_POS;
        end
    end

    assign s3_sum_next = s2_prod_reg + rnd_term;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_sum_reg  <= s3_sum_next;
            s3_clip_reg <= s2_clip_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: floor shift (single) or truncating divide by 2^31 (double).
    // ------------------------------------------------------------------
    logic               trunc_fix;
    logic signed [63:0] s4_val_next;
    logic signed [63:0] s4_val_reg;
    logic               s4_clip_reg;
    logic               s4_last_reg;

    assign trunc_fix = s3_sum_reg[63] && (s3_sum_reg[30:0] != 31'd0);

    always_comb
    begin
        if (cfg.rounding_mode == MODE_SINGLE)
        begin
            s4_val_next = s3_sum_reg >>> s_amt;
        end
        else
        begin
            s4_val_next = (s3_sum_reg >>> 31) + $signed({63'd0, trunc_fix});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_val_reg  <= s4_val_next;
            s4_clip_reg <= s3_clip_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: rounding divide by 2^rs, ties away from zero (double only).
    // ------------------------------------------------------------------
    logic [63:0]        rd_mask;
    logic [63:0]        rd_rem;
    logic [63:0]        rd_thr;
    logic               rd_up;
    logic signed [63:0] s5_val_next;
    logic signed [63:0] s5_val_reg;
    logic               s5_clip_reg;
    logic               s5_last_reg;

    assign rd_mask = (64'd1 << rs_amt) - 64'd1;
    assign rd_rem  = s4_val_reg & rd_mask;
    assign rd_thr  = (rd_mask >> 1) + {63'd0, s4_val_reg[63]};
    assign rd_up   = rd_rem > rd_thr;

    always_comb
    begin
        if (cfg.rounding_mode == MODE_SINGLE)
        begin
            s5_val_next = s4_val_reg;
        end
        else
        begin
            s5_val_next = (s4_val_reg >>> rs_amt) + $signed({63'd0, rd_up});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_val_reg  <= s5_val_next;
            s5_clip_reg <= s4_clip_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: saturate to int32 into the output register.
    // ------------------------------------------------------------------
    sat_t               out_sat;
    logic signed [31:0] s6_val_reg;
    logic               s6_clip_reg;
    logic               s6_last_reg;

    assign out_sat = sat_int32(s5_val_reg);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_val_reg  <= out_sat.val;
            s6_clip_reg <= out_sat.clip || s5_clip_reg;
            s6_last_reg <= s5_last_reg;
        end
    end

    assign res_valid    = vld_reg[NUM_STAGES];
    assign scaled_value = s6_val_reg;
    assign clipped      = s6_clip_reg;
    assign last_out     = s6_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Occupancy moves only with accepted input and output beats.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(vld_reg) == $past($countones(vld_reg))
                  + int'($past(acc_valid && acc_ready))
                  - int'($past(res_valid && res_ready)))
        else $error("pipeline occupancy lost or duplicated a beat");

    // A full stage blocked from behind holds its payload.
    a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] && !adv[5] |=> vld_reg[5] && $stable(s5_val_reg))
        else $error("stalled stage 5 lost its payload");

    // In single rounding a clamp can only come from the output saturation,
    // so a clamped result sits on one of the int32 rails.
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && clipped && cfg.rounding_mode == MODE_SINGLE |->
            scaled_value == 32'sh7FFF_FFFF || scaled_value == 32'sh8000_0000)
        else $error("clipped result is not at an int32 limit");

    // Single rounding never clamps before the multiply.
    a_single_no_preclip: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] && cfg.rounding_mode == MODE_SINGLE |-> !s1_clip_reg)
        else $error("pre-shift clamp flagged in single rounding");

endmodule
